// ----- sv/obk_pkg.sv -----
`timescale 1ns / 1ps

package obk_pkg;

    localparam int BOOK_ENTRIES = 1024;
    localparam int ADDR_W       = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(BOOK_ENTRIES + 1);

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(BOOK_ENTRIES);

    localparam logic [6:0] CHAR_A = 7'd97;   // 'a'
    localparam logic [5:0] CHAR_1 = 6'd49;   // '0' + 1

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISS     = 3'd3,
        ST_BADPROMO = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] move;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        status_t     status;
        logic [6:0]  from_file;
        logic [5:0]  from_rank;
        logic [6:0]  to_file;
        logic [5:0]  to_rank;
        logic [6:0]  promo;
        logic [15:0] move;
    } result_t;

    function automatic logic [63:0] swap64(logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic logic [15:0] swap16(logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic result_t empty_result(status_t st);
        result_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    function automatic logic [6:0] promo_letter(logic [2:0] code);
        logic [6:0] c;
        unique case (code)
            3'd1:    c = 7'd110;  // n
            3'd2:    c = 7'd98;   // b
            3'd3:    c = 7'd114;  // r
            3'd4:    c = 7'd113;  // q
            default: c = 7'd0;
        endcase
        return c;
    endfunction

    function automatic result_t decode_move(logic [15:0] mv);
        result_t r;
        r.from_file = CHAR_A + 7'(mv[8:6]);
        r.from_rank = CHAR_1 + 6'(mv[11:9]);
        r.to_file   = CHAR_A + 7'(mv[2:0]);
        r.to_rank   = CHAR_1 + 6'(mv[5:3]);
        r.move      = mv;
        if (mv[15:12] <= 4'd4)
        begin
            r.status = ST_FOUND;
            r.promo  = promo_letter(mv[14:12]);
        end
        else
        begin
            r.status = ST_BADPROMO;
            r.promo  = 7'd0;
        end
        return r;
    endfunction

endpackage

// ----- sv/obk_book_ram.sv -----
`timescale 1ns / 1ps

// Book entry store: one write port, one read port, registered read data.
module obk_book_ram
    import obk_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output entry_t   rd_data
);

    entry_t mem [BOOK_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- sv/opening_book_key_search.sv -----
`timescale 1ns / 1ps

// Opening-book key search. Holds up to BOOK_ENTRIES (1024) entries of a byte-swapped
// 64-bit position key and 16-bit move in one synchronous RAM. Each request carries an
// operation: clear (count reset to zero), append (swap and store at the next slot, status
// "full" once all slots are used) or lookup (first stored key equal to the hash, in load
// order, decoded into square and promotion characters). One request is worked at a time.
// Clear, append and the unused code go from IDLE to EMIT, where the result is loaded
// into the output register once the output slot is free. A lookup scans the RAM one
// entry per cycle through its single read port until the first match or the last
// stored entry (none on an empty store), then goes through EMIT the same way. The next
// request is taken in the cycle after the result is loaded into the output register,
// even if that result has not yet been taken downstream. No clearing pass is needed
// after reset.
module opening_book_key_search
    import obk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [63:0] key_value,
    input  logic [15:0] move_value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [6:0]  from_file_char,
    output logic [5:0]  from_rank_char,
    output logic [6:0]  to_file_char,
    output logic [5:0]  to_rank_char,
    output logic [6:0]  promotion_char,
    output logic [15:0] move_word
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;   // stored entries
    logic [CNT_W-1:0]  idx_reg,   idx_next;     // next entry to read during a scan
    logic              pend_reg,  pend_next;    // read data valid this cycle
    logic [63:0]       hash_reg,  hash_next;
    result_t           res_reg,   res_next;     // finished result awaiting the output slot
    result_t           out_reg,   out_next;
    logic              out_valid_reg, out_valid_next;

    ram_req_t          ram_req;
    entry_t            rd_data;

    logic              accept;
    logic              issue;
    logic              hit;
    logic              scan_done;
    logic              slot_free;
    op_t               op;

    assign op        = op_t'(operation);
    assign accept    = in_valid && in_ready;
    assign issue     = idx_reg < count_reg;
    assign hit       = pend_reg && (rd_data.key == hash_reg);
    assign scan_done = !pend_reg && !issue;
    assign slot_free = !out_valid_reg || out_ready;

    obk_book_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op == OP_LOOKUP) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (hit || scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath. Appends write only from IDLE and scans read only in SCAN,
    // so a read never overlaps a write to the same entry.
    always_comb
    begin
        in_ready        = 1'b0;
        ram_req         = '0;
        ram_req.wr_addr = count_reg[ADDR_W-1:0];
        ram_req.wr_data = '{key: swap64(key_value), move: swap16(move_value)};
        ram_req.rd_addr = idx_reg[ADDR_W-1:0];
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        hash_next       = hash_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next  = empty_result(ST_DONE);
                    hash_next = key_value;
                    idx_next  = '0;
                    unique case (op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg == COUNT_FULL)
                            begin
                                res_next = empty_result(ST_FULL);
                            end
                            else
                            begin
                                ram_req.wr_en = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next = decode_move(rd_data.move);
                end
                else if (scan_done)
                begin
                    res_next = empty_result(ST_MISS);
                end
                else if (issue)
                begin
                    ram_req.rd_en = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign from_file_char = out_reg.from_file;
    assign from_rank_char = out_reg.from_rank;
    assign to_file_char   = out_reg.to_file;
    assign to_rank_char   = out_reg.to_rank;
    assign promotion_char = out_reg.promo;
    assign move_word      = out_reg.move;

    // Checks

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count beyond store size");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == S_SCAN)
        else $error("read data pending outside a scan");

    a_found_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FOUND) |->
            (from_file_char == CHAR_A + 7'(move_word[8:6]) &&
             to_rank_char == CHAR_1 + 6'(move_word[5:3]))
        )
        else $error("found result does not match its move word");

    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_MISS) |-> move_word == 16'd0)
        else $error("miss result carries a move");

endmodule
